// ===== sv/assert_macros.svh =====
// assertion helpers, sampled on clk and disabled while rst_n is low
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef NO_ASSERTIONS

`define ASSERT_ALWAYS(label, prop) \
    label: assert property (@(posedge clk) disable iff (!rst_n) prop) \
        else $error("assertion failed");

`define ASSERT_NEXT(label, cond, expect_next) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (cond) |=> (expect_next)) \
        else $error("assertion failed");

`else

`define ASSERT_ALWAYS(label, prop)

`define ASSERT_NEXT(label, cond, expect_next)

`endif

`endif

// ===== sv/cbe_pkg.sv =====
package cbe_pkg;

    localparam int MAP_ENTRIES = 8;
    localparam int QUEUE_DEPTH = 4;
    localparam int QPTR_W      = $clog2(QUEUE_DEPTH);
    localparam int QCNT_W      = $clog2(QUEUE_DEPTH + 1);

    localparam logic [7:0] GB_LEAD_MIN  = 8'h81;
    localparam logic [7:0] GB_LEAD_MAX  = 8'hFE;
    localparam logic [7:0] GB_TRAIL_MIN = 8'h40;
    localparam logic [7:0] GB_TRAIL_GAP = 8'h7F;
    localparam logic [7:0] DIGIT_MIN    = 8'h30;
    localparam logic [7:0] DIGIT_MAX    = 8'h39;
    localparam logic [7:0] ASCII_LIMIT  = 8'h80;

    localparam logic [2:0] CFG_LEAD_SEP  = 3'd0;
    localparam logic [2:0] CFG_SURROUND  = 3'd1;
    localparam logic [2:0] CFG_ENV       = 3'd2;
    localparam logic [2:0] CFG_MAP_FROM  = 3'd3;
    localparam logic [2:0] CFG_MAP_TO    = 3'd4;
    localparam logic [2:0] CFG_MAP_COUNT = 3'd5;
    localparam logic [2:0] CFG_GB_MODE   = 3'd6;
    localparam logic [2:0] CFG_OUT_LIMIT = 3'd7;

    typedef struct packed {
        logic [15:0] lead_sep_chars;
        logic [15:0] surround_chars;
        logic [23:0] env_chars;
        logic [63:0] map_from;
        logic [63:0] map_to;
        logic [3:0]  map_count;
        logic        gb_mode;
        logic [15:0] out_limit;
    } cbe_cfg_t;

    typedef struct packed {
        logic        last;
        logic        is_end;
        logic        ovf;
        logic [15:0] total;
        logic [2:0]  len;
        logic [31:0] bytes;
    } cbe_unit_t;

    function automatic logic [7:0] escape_code(input logic [7:0] c, input cbe_cfg_t cfg);
        logic [7:0] lead;
        logic [7:0] sep;
        logic [7:0] s0;
        logic [7:0] s1;
        logic [7:0] e0;
        logic [7:0] e1;
        logic [7:0] e2;
        logic [7:0] code;
        logic [3:0] n;
        int         i;
        begin
            lead = cfg.lead_sep_chars[7:0];
            sep  = cfg.lead_sep_chars[15:8];
            s0   = cfg.surround_chars[7:0];
            s1   = cfg.surround_chars[15:8];
            e0   = cfg.env_chars[7:0];
            e1   = cfg.env_chars[15:8];
            e2   = cfg.env_chars[23:16];
            n    = (cfg.map_count > 4'(MAP_ENTRIES)) ? 4'(MAP_ENTRIES) : cfg.map_count;
            code = 8'h00;
            // descending so the lowest matching entry wins
            for (i = MAP_ENTRIES - 1; i >= 0; i--)
            begin
                if ((4'(i) < n) && (cfg.map_from[8*i +: 8] == c))
                begin
                    code = cfg.map_to[8*i +: 8];
                end
            end
            if (c >= ASCII_LIMIT)
            begin
                code = 8'h00;
            end
            else if (c == lead)
            begin
                code = lead;
            end
            else if ((s0 != 8'h00) && ((c == s0) || (c == s1)))
            begin
                code = c;
            end
            else if ((e0 != 8'h00) && ((c == e0) || (c == e1) || (c == e2)))
            begin
                code = c;
            end
            else if (c == sep)
            begin
                code = sep;
            end
            return code;
        end
    endfunction

    function automatic logic is_gb_lead(input logic [7:0] b);
        return (b >= GB_LEAD_MIN) && (b <= GB_LEAD_MAX);
    endfunction

    function automatic logic is_digit(input logic [7:0] b);
        return (b >= DIGIT_MIN) && (b <= DIGIT_MAX);
    endfunction

    // length of the unit at the front of the work bytes: 1, 2, 4, or 0 to wait
    function automatic logic [2:0] unit_span(input logic [31:0] w, input logic [2:0] wn,
                                             input logic gb, input logic at_end);
        logic [2:0] span;
        logic [2:0] wait_span;
        begin
            wait_span = at_end ? 3'd1 : 3'd0;
            if (!gb || !is_gb_lead(w[7:0]))
            begin
                span = 3'd1;
            end
            else if (wn < 3'd2)
            begin
                span = wait_span;
            end
            else if ((w[15:8] >= GB_TRAIL_MIN) && (w[15:8] <= GB_LEAD_MAX)
                     && (w[15:8] != GB_TRAIL_GAP))
            begin
                span = 3'd2;
            end
            else if (!is_digit(w[15:8]))
            begin
                span = 3'd1;
            end
            else if (wn < 3'd3)
            begin
                span = wait_span;
            end
            else if (!is_gb_lead(w[23:16]))
            begin
                span = 3'd1;
            end
            else if (wn < 3'd4)
            begin
                span = wait_span;
            end
            else
            begin
                span = is_digit(w[31:24]) ? 3'd4 : 3'd1;
            end
            return span;
        end
    endfunction

endpackage

// ===== sv/cbe_front.sv =====
module cbe_front (
    input  logic                clk,
    input  logic                rst_n,
    input  cbe_pkg::cbe_cfg_t   cfg,
    input  logic                in_valid,
    output logic                in_ready,
    input  logic [7:0]          in_byte,
    output logic                push,
    output cbe_pkg::cbe_unit_t  push_unit,
    input  logic                room
);
    import cbe_pkg::*;

    logic [31:0] work_reg, work_next;
    logic [2:0]  wn_reg, wn_next;
    logic        pend_end_reg, pend_end_next;
    logic [15:0] pos_reg, pos_next;
    logic        ovf_reg, ovf_next;
    logic        hold_valid_reg, hold_valid_next;
    logic        hold_done_reg, hold_done_next;
    logic        active_reg, active_next;
    cbe_unit_t   hold_reg, hold_next;

    logic [2:0]  span;
    logic [2:0]  span_after;
    logic        settled;
    logic [7:0]  code;
    logic        step;
    logic        end_step;
    logic [2:0]  unit_len;
    logic [31:0] unit_bytes;
    logic [16:0] sum;
    logic        fits;
    logic        emits;
    logic        fin;
    logic [31:0] shifted;
    logic [2:0]  shift_wn;
    logic        flush;
    cbe_unit_t   new_unit;

    always_comb
    begin
        span     = unit_span(work_reg, wn_reg, cfg.gb_mode, pend_end_reg);
        settled  = !pend_end_reg && ((wn_reg == 3'd0) || (span == 3'd0));
        code     = escape_code(work_reg[7:0], cfg);
        end_step = pend_end_reg && (wn_reg == 3'd0);
        // held bytes are judged only once a new beat has arrived
        step     = active_reg && !settled && room;

        if ((span == 3'd1) && (code != 8'h00))
        begin
            unit_len   = 3'd2;
            unit_bytes = {16'h0000, code, cfg.lead_sep_chars[7:0]};
        end
        else
        begin
            unit_len   = span;
            unit_bytes = work_reg;
        end

        sum  = {1'b0, pos_reg} + {14'h0000, unit_len};
        fits = !ovf_reg && (sum < {1'b0, cfg.out_limit});

        unique case (span)
            3'd1:    shifted = {8'h00, work_reg[31:8]};
            3'd2:    shifted = {16'h0000, work_reg[31:16]};
            3'd4:    shifted = 32'h0000_0000;
            default: shifted = work_reg;
        endcase
        shift_wn   = wn_reg - span;
        span_after = unit_span(shifted, shift_wn, cfg.gb_mode, 1'b0);

        if (end_step)
        begin
            fin = 1'b1;
        end
        else
        begin
            fin = !pend_end_reg && ((shift_wn == 3'd0) || (span_after == 3'd0));
        end
        emits = end_step || fits;

        new_unit        = '0;
        new_unit.is_end = end_step;
        if (end_step)
        begin
            new_unit.ovf   = ovf_reg;
            new_unit.total = pos_reg;
        end
        else
        begin
            new_unit.len   = unit_len;
            new_unit.bytes = unit_bytes;
        end

        flush    = hold_valid_reg && hold_done_reg && room;
        in_ready = (settled || !active_reg) && (!hold_done_reg || room);

        push           = flush || (step && emits && hold_valid_reg);
        push_unit      = hold_reg;
        push_unit.last = hold_done_reg;
    end

    always_comb
    begin
        work_next       = work_reg;
        wn_next         = wn_reg;
        pend_end_next   = pend_end_reg;
        pos_next        = pos_reg;
        ovf_next        = ovf_reg;
        hold_valid_next = hold_valid_reg;
        hold_done_next  = hold_done_reg;
        active_next     = active_reg;
        hold_next       = hold_reg;

        if (flush)
        begin
            hold_valid_next = 1'b0;
            hold_done_next  = 1'b0;
        end

        if (in_valid && in_ready)
        begin
            active_next = 1'b1;
            if (in_byte == 8'h00)
            begin
                pend_end_next = 1'b1;
            end
            else
            begin
                work_next[8*wn_reg[1:0] +: 8] = in_byte;
                wn_next = wn_reg + 3'd1;
            end
        end
        else if (settled)
        begin
            active_next = 1'b0;
        end

        if (step)
        begin
            if (end_step)
            begin
                pend_end_next = 1'b0;
                pos_next      = 16'h0000;
                ovf_next      = 1'b0;
                work_next     = 32'h0000_0000;
            end
            else
            begin
                work_next = shifted;
                wn_next   = shift_wn;
                if (fits)
                begin
                    pos_next = sum[15:0];
                end
                else
                begin
                    ovf_next = 1'b1;
                end
            end

            if (emits)
            begin
                hold_next       = new_unit;
                hold_valid_next = 1'b1;
                hold_done_next  = fin;
            end
            else if (fin && hold_valid_reg)
            begin
                hold_done_next = 1'b1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            work_reg       <= 32'h0000_0000;
            wn_reg         <= 3'd0;
            pend_end_reg   <= 1'b0;
            pos_reg        <= 16'h0000;
            ovf_reg        <= 1'b0;
            hold_valid_reg <= 1'b0;
            hold_done_reg  <= 1'b0;
            active_reg     <= 1'b0;
        end
        else
        begin
            work_reg       <= work_next;
            wn_reg         <= wn_next;
            pend_end_reg   <= pend_end_next;
            pos_reg        <= pos_next;
            ovf_reg        <= ovf_next;
            hold_valid_reg <= hold_valid_next;
            hold_done_reg  <= hold_done_next;
            active_reg     <= active_next;
        end
    end

    always_ff @(posedge clk)
    begin
        hold_reg <= hold_next;
    end

endmodule

// ===== sv/cbe_queue.sv =====
module cbe_queue (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                push,
    input  cbe_pkg::cbe_unit_t  push_unit,
    output logic                room,
    input  logic                pop,
    output cbe_pkg::cbe_unit_t  head_unit,
    output logic                not_empty
);
    import cbe_pkg::*;

    cbe_unit_t         mem_reg [QUEUE_DEPTH];
    logic [QPTR_W-1:0] wr_ptr_reg, wr_ptr_next;
    logic [QPTR_W-1:0] rd_ptr_reg, rd_ptr_next;
    logic [QCNT_W-1:0] count_reg, count_next;

    always_comb
    begin
        room      = (count_reg != QCNT_W'(QUEUE_DEPTH));
        not_empty = (count_reg != '0);
        head_unit = mem_reg[rd_ptr_reg];

        wr_ptr_next = push ? wr_ptr_reg + 1'b1 : wr_ptr_reg;
        rd_ptr_next = pop ? rd_ptr_reg + 1'b1 : rd_ptr_reg;
        count_next  = count_reg;
        if (push && !pop)
        begin
            count_next = count_reg + 1'b1;
        end
        else if (pop && !push)
        begin
            count_next = count_reg - 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            mem_reg[wr_ptr_reg] <= push_unit;
        end
    end

endmodule

// ===== sv/cbe_back.sv =====
module cbe_back (
    input  logic                clk,
    input  logic                rst_n,
    input  cbe_pkg::cbe_unit_t  head_unit,
    input  logic                not_empty,
    output logic                pop,
    output logic                out_valid,
    input  logic                out_ready,
    output logic [7:0]          out_byte,
    output logic                has_byte,
    output logic                string_end,
    output logic                overflow,
    output logic [15:0]         total_length,
    output logic                last_of_run
);
    import cbe_pkg::*;

    logic [1:0]  idx_reg, idx_next;
    logic        valid_reg, valid_next;
    logic [7:0]  byte_reg, byte_next;
    logic        has_reg, has_next;
    logic        end_reg, end_next;
    logic        ovf_reg, ovf_next;
    logic [15:0] total_reg, total_next;
    logic        last_reg, last_next;

    logic        load;
    logic        unit_done;
    logic [7:0]  byte_sel;

    always_comb
    begin
        load      = not_empty && (!valid_reg || out_ready);
        byte_sel  = head_unit.bytes[8*idx_reg +: 8];
        unit_done = head_unit.is_end || ({1'b0, idx_reg} == (head_unit.len - 3'd1));
        pop       = load && unit_done;

        idx_next   = idx_reg;
        valid_next = valid_reg;
        byte_next  = byte_reg;
        has_next   = has_reg;
        end_next   = end_reg;
        ovf_next   = ovf_reg;
        total_next = total_reg;
        last_next  = last_reg;

        if (load)
        begin
            valid_next = 1'b1;
            idx_next   = unit_done ? 2'd0 : idx_reg + 2'd1;
            byte_next  = head_unit.is_end ? 8'h00 : byte_sel;
            has_next   = !head_unit.is_end;
            end_next   = head_unit.is_end;
            ovf_next   = head_unit.is_end && head_unit.ovf;
            total_next = head_unit.is_end ? head_unit.total : 16'h0000;
            last_next  = head_unit.last && unit_done;
        end
        else if (out_ready)
        begin
            valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            idx_reg   <= 2'd0;
            valid_reg <= 1'b0;
        end
        else
        begin
            idx_reg   <= idx_next;
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        byte_reg  <= byte_next;
        has_reg   <= has_next;
        end_reg   <= end_next;
        ovf_reg   <= ovf_next;
        total_reg <= total_next;
        last_reg  <= last_next;
    end

    assign out_valid    = valid_reg;
    assign out_byte     = byte_reg;
    assign has_byte     = has_reg;
    assign string_end   = end_reg;
    assign overflow     = ovf_reg;
    assign total_length = total_reg;
    assign last_of_run  = last_reg;

endmodule

// ===== sv/configurable_byte_escaper_core.sv =====
// path: a byte that completes a unit passes the work, hold, queue and output registers
// input: the front takes a new byte only once its held bytes have been classified
// output: one beat per ready cycle; an escape or gbk pair is 2 beats, gb18030 sequence 4
// reset: rst_n clears lookahead, position, overflow flag, queue and output valid,
//        and loads the register defaults
`include "assert_macros.svh"

module configurable_byte_escaper_core (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        cfg_valid,
    output logic        cfg_ready,
    input  logic [2:0]  cfg_index,
    input  logic [63:0] cfg_data,
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    input  logic [7:0]  s_axis_tdata,   // [7:0] data_byte
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    output logic [31:0] m_axis_tdata,   // [7:0] out_byte, [8] overflow, [24:9] total_length
    output logic [1:0]  m_axis_tuser,   // [0] has_byte, [1] string_end
    output logic        m_axis_tlast
);
    import cbe_pkg::*;

    cbe_cfg_t  cfg_reg, cfg_next;
    logic      q_push;
    cbe_unit_t q_push_unit;
    logic      q_room;
    logic      q_pop;
    cbe_unit_t q_head;
    logic      q_not_empty;
    logic [7:0]  out_byte;
    logic        overflow;
    logic [15:0] total_length;

    assign cfg_ready = 1'b1;

    always_comb
    begin
        cfg_next = cfg_reg;
        if (cfg_valid && cfg_ready)
        begin
            unique case (cfg_index)
                CFG_LEAD_SEP:  cfg_next.lead_sep_chars = cfg_data[15:0];
                CFG_SURROUND:  cfg_next.surround_chars = cfg_data[15:0];
                CFG_ENV:       cfg_next.env_chars      = cfg_data[23:0];
                CFG_MAP_FROM:  cfg_next.map_from       = cfg_data;
                CFG_MAP_TO:    cfg_next.map_to         = cfg_data;
                CFG_MAP_COUNT: cfg_next.map_count      = cfg_data[3:0];
                CFG_GB_MODE:   cfg_next.gb_mode        = cfg_data[0];
                CFG_OUT_LIMIT: cfg_next.out_limit      = cfg_data[15:0];
                default:       cfg_next                = cfg_reg;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg <= '{lead_sep_chars: 16'd92, out_limit: 16'd256, default: '0};
        end
        else
        begin
            cfg_reg <= cfg_next;
        end
    end

    cbe_front u_front (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg       (cfg_reg),
        .in_valid  (s_axis_tvalid),
        .in_ready  (s_axis_tready),
        .in_byte   (s_axis_tdata),
        .push      (q_push),
        .push_unit (q_push_unit),
        .room      (q_room)
    );

    cbe_queue u_queue (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (q_push),
        .push_unit (q_push_unit),
        .room      (q_room),
        .pop       (q_pop),
        .head_unit (q_head),
        .not_empty (q_not_empty)
    );

    cbe_back u_back (
        .clk          (clk),
        .rst_n        (rst_n),
        .head_unit    (q_head),
        .not_empty    (q_not_empty),
        .pop          (q_pop),
        .out_valid    (m_axis_tvalid),
        .out_ready    (m_axis_tready),
        .out_byte     (out_byte),
        .has_byte     (m_axis_tuser[0]),
        .string_end   (m_axis_tuser[1]),
        .overflow     (overflow),
        .total_length (total_length),
        .last_of_run  (m_axis_tlast)
    );

    assign m_axis_tdata = {7'h00, total_length, overflow, out_byte};

    `ASSERT_ALWAYS(a_no_push_when_full, q_push |-> q_room)
    `ASSERT_ALWAYS(a_no_pop_when_empty, q_pop |-> q_not_empty)
    `ASSERT_ALWAYS(a_end_beat_closes_run, (m_axis_tvalid && m_axis_tuser[1]) |-> (m_axis_tlast && !m_axis_tuser[0]))
    `ASSERT_NEXT(a_stalled_beat_kept, m_axis_tvalid && !m_axis_tready, m_axis_tvalid)

endmodule

// ===== verif/tb_top.sv =====
module tb_top;

    timeunit 1ns;
    timeprecision 1ps;

    import cbe_pkg::*;

    localparam int CYCLE_LIMIT   = 1000000;
    localparam int RANDOM_ITEMS  = 470;
    localparam int SETTLE_CYCLES = 16;
    localparam int LONG_HOLD     = 300;

    typedef struct {
        logic [7:0]  ch;
        logic        has_byte;
        logic        last;
        logic        str_end;
        logic        ovf;
        logic [15:0] total;
    } esc_beat_t;

    logic        clk           = 1'b0;
    logic        rst_n         = 1'b0;
    logic        cfg_valid     = 1'b0;
    logic        cfg_ready;
    logic [2:0]  cfg_index     = '0;
    logic [63:0] cfg_data      = '0;
    logic        s_axis_tvalid = 1'b0;
    logic        s_axis_tready;
    logic [7:0]  s_axis_tdata  = '0;   // [7:0] data_byte
    logic        m_axis_tvalid;
    logic        m_axis_tready = 1'b0;
    logic [31:0] m_axis_tdata;         // [7:0] out_byte, [8] overflow, [24:9] total_length
    logic [1:0]  m_axis_tuser;         // [0] has_byte, [1] string_end
    logic        m_axis_tlast;

    // register copies for prediction
    logic [15:0] rg_lead_sep  = 16'd92;
    logic [15:0] rg_surround  = '0;
    logic [23:0] rg_env       = '0;
    logic [63:0] rg_map_from  = '0;
    logic [63:0] rg_map_to    = '0;
    logic [3:0]  rg_map_count = '0;
    logic        rg_gb        = 1'b0;
    logic [15:0] rg_out_limit = 16'd256;

    // escaper state for prediction
    logic [23:0] held_bytes = '0;
    int          held_n     = 0;
    int          out_pos    = 0;
    bit          ovf_seen   = 1'b0;

    esc_beat_t   step_q[$];
    esc_beat_t   exp_q[$];
    logic [7:0]  tx_q[$];

    bit          src_idle_on  = 1'b0;
    bit          sink_idle_on = 1'b0;
    int          src_gap      = 0;
    int          sink_gap     = 0;
    int          sink_hold    = 0;
    int          hold_req     = 0;
    int          hold_done    = 0;

    int          cycle_cnt    = 0;
    int          err_count    = 0;
    int          bytes_in     = 0;
    int          beats_seen   = 0;
    int          strings_done = 0;
    int          ovf_strings  = 0;
    int          reg_writes   = 0;
    int          stim_items   = 0;

    configurable_byte_escaper_core i_dut (
        .clk           (clk),
        .rst_n         (rst_n),
        .cfg_valid     (cfg_valid),
        .cfg_ready     (cfg_ready),
        .cfg_index     (cfg_index),
        .cfg_data      (cfg_data),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tuser  (m_axis_tuser),
        .m_axis_tlast  (m_axis_tlast)
    );

    always
    begin
        #6 clk = 1'b1;
        #6 clk = 1'b0;
    end

    function automatic logic [7:0] escape_for(input logic [7:0] c);
        int i;
        int n;
        n = (rg_map_count > 4'd8) ? 8 : int'(rg_map_count);
        if (c >= ASCII_LIMIT)
            return 8'h00;
        if (c == rg_lead_sep[7:0])
            return c;
        if ((rg_surround[7:0] != 8'h00) && ((c == rg_surround[7:0]) || (c == rg_surround[15:8])))
            return c;
        if ((rg_env[7:0] != 8'h00)
            && ((c == rg_env[7:0]) || (c == rg_env[15:8]) || (c == rg_env[23:16])))
            return c;
        if (c == rg_lead_sep[15:8])
            return c;
        for (i = 0; i < n; i++)
        begin
            if (rg_map_from[8*i +: 8] == c)
                return rg_map_to[8*i +: 8];
        end
        return 8'h00;
    endfunction

    // bytes taken by the unit at the front, 0 while a multibyte sequence is incomplete and the string has not ended
    function automatic int gb_span(input logic [31:0] w, input int wn, input bit at_end);
        logic [7:0] b0;
        logic [7:0] b1;
        logic [7:0] b2;
        logic [7:0] b3;
        int         short_span;
        b0 = w[7:0];
        b1 = w[15:8];
        b2 = w[23:16];
        b3 = w[31:24];
        short_span = at_end ? 1 : 0;
        if (!rg_gb || (b0 < GB_LEAD_MIN) || (b0 > GB_LEAD_MAX))
            return 1;
        if (wn < 2)
            return short_span;
        if ((b1 >= GB_TRAIL_MIN) && (b1 <= GB_LEAD_MAX) && (b1 != GB_TRAIL_GAP))
            return 2;
        if ((b1 < DIGIT_MIN) || (b1 > DIGIT_MAX))
            return 1;
        if (wn < 3)
            return short_span;
        if ((b2 < GB_LEAD_MIN) || (b2 > GB_LEAD_MAX))
            return 1;
        if (wn < 4)
            return short_span;
        return ((b3 >= DIGIT_MIN) && (b3 <= DIGIT_MAX)) ? 4 : 1;
    endfunction

    task automatic emit_unit(input logic [31:0] unit_bytes, input int len);
        esc_beat_t bt;
        int        i;
        if (ovf_seen)
            return;
        if (out_pos + len >= int'(rg_out_limit))
        begin
            ovf_seen = 1'b1;
            return;
        end
        for (i = 0; i < len; i++)
        begin
            bt.ch       = unit_bytes[8*i +: 8];
            bt.has_byte = 1'b1;
            bt.last     = 1'b0;
            bt.str_end  = 1'b0;
            bt.ovf      = 1'b0;
            bt.total    = '0;
            step_q.push_back(bt);
        end
        out_pos = (out_pos + len) & 32'hFFFF;
    endtask

    task automatic predict_byte(input logic [7:0] d);
        logic [31:0] work;
        logic [7:0]  code;
        int          wn;
        int          k;
        bit          at_end;
        esc_beat_t   bt;
        at_end = (d == 8'h00);
        step_q.delete();
        work = {8'h00, held_bytes};
        wn   = held_n;
        if (!at_end)
        begin
            work[8*wn +: 8] = d;
            wn++;
        end
        while (wn > 0)
        begin
            k = gb_span(work, wn, at_end);
            if (k == 0)
                break;
            if (k == 1)
            begin
                code = escape_for(work[7:0]);
                if (code == 8'h00)
                    emit_unit({24'h0, work[7:0]}, 1);
                else
                    emit_unit({16'h0, code, rg_lead_sep[7:0]}, 2);
            end
            else
            begin
                emit_unit(work, k);
            end
            work = work >> (8 * k);
            wn   = wn - k;
        end
        if (at_end)
        begin
            bt.ch       = 8'h00;
            bt.has_byte = 1'b0;
            bt.last     = 1'b0;
            bt.str_end  = 1'b1;
            bt.ovf      = ovf_seen;
            bt.total    = out_pos[15:0];
            step_q.push_back(bt);
            wn       = 0;
            work     = '0;
            out_pos  = 0;
            ovf_seen = 1'b0;
        end
        held_bytes = work[23:0];
        held_n     = wn;
        if (step_q.size() > 0)
            step_q[step_q.size() - 1].last = 1'b1;
        foreach (step_q[i])
            exp_q.push_back(step_q[i]);
    endtask

    function automatic int pick_gap(input bit idle_on);
        int r;
        r = $urandom_range(0, 99);
        if (!idle_on || r < 60)
            return 0;
        if (r < 93)
            return $urandom_range(1, 3);
        return $urandom_range(8, 40);
    endfunction

    task automatic check_beat();
        esc_beat_t e;
        logic [7:0]  got_ch;
        logic        got_ovf;
        logic [15:0] got_total;
        logic        got_has;
        logic        got_end;
        got_ch    = m_axis_tdata[7:0];
        got_ovf   = m_axis_tdata[8];
        got_total = m_axis_tdata[24:9];
        got_has   = m_axis_tuser[0];
        got_end   = m_axis_tuser[1];
        beats_seen++;
        if (exp_q.size() == 0)
        begin
            err_count++;
            if (err_count <= 10)
                $display("beat %0d unexpected: byte=%h has=%b last=%b end=%b ovf=%b total=%0d",
                         beats_seen, got_ch, got_has, m_axis_tlast, got_end, got_ovf, got_total);
            return;
        end
        e = exp_q.pop_front();
        if (e.str_end)
        begin
            strings_done++;
            if (e.ovf)
                ovf_strings++;
        end
        if ((got_ch !== e.ch) || (got_has !== e.has_byte) || (m_axis_tlast !== e.last)
            || (got_end !== e.str_end) || (got_ovf !== e.ovf) || (got_total !== e.total))
        begin
            err_count++;
            if (err_count <= 10)
            begin
                $display("beat %0d mismatch: exp byte=%h has=%b last=%b end=%b ovf=%b total=%0d",
                         beats_seen, e.ch, e.has_byte, e.last, e.str_end, e.ovf, e.total);
                $display("                   got byte=%h has=%b last=%b end=%b ovf=%b total=%0d",
                         got_ch, got_has, m_axis_tlast, got_end, got_ovf, got_total);
            end
        end
    endtask

    // input driver
    always @(posedge clk or negedge rst_n)
    begin
        logic       nxt_valid;
        logic [7:0] nxt_data;
        if (!rst_n)
        begin
            s_axis_tvalid <= 1'b0;
            s_axis_tdata  <= '0;
        end
        else
        begin
            nxt_valid = s_axis_tvalid;
            nxt_data  = s_axis_tdata;
            if (s_axis_tvalid && s_axis_tready)
            begin
                predict_byte(s_axis_tdata);
                bytes_in++;
                nxt_valid = 1'b0;
                src_gap   = pick_gap(src_idle_on);
            end
            if (!nxt_valid)
            begin
                if (src_gap > 0)
                begin
                    src_gap--;
                end
                else if (tx_q.size() > 0)
                begin
                    nxt_data  = tx_q.pop_front();
                    nxt_valid = 1'b1;
                end
            end
            s_axis_tvalid <= nxt_valid;
            s_axis_tdata  <= nxt_data;
        end
    end

    // output monitor and receiver stalls
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            m_axis_tready <= 1'b0;
        end
        else
        begin
            if (m_axis_tvalid && m_axis_tready)
            begin
                check_beat();
                sink_gap = pick_gap(sink_idle_on);
            end
            else if (sink_idle_on && (sink_gap == 0) && ($urandom_range(0, 15) == 0))
            begin
                sink_gap = $urandom_range(1, 4);
            end
            if (hold_req != hold_done)
            begin
                hold_done = hold_req;
                sink_hold = LONG_HOLD;
            end
            if (sink_hold > 0)
            begin
                sink_hold--;
                m_axis_tready <= 1'b0;
            end
            else if (sink_gap > 0)
            begin
                sink_gap--;
                m_axis_tready <= 1'b0;
            end
            else
            begin
                m_axis_tready <= 1'b1;
            end
        end
    end

    always @(posedge clk)
    begin
        cycle_cnt++;
        if (cycle_cnt > CYCLE_LIMIT)
        begin
            $display("watchdog expired at cycle %0d, %0d beats outstanding",
                     cycle_cnt, exp_q.size());
            $display("status: fail");
            $finish;
        end
    end

    task automatic write_reg(input logic [2:0] idx, input logic [63:0] val);
        @(posedge clk);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= val;
        @(posedge clk);
        while (!cfg_ready)
            @(posedge clk);
        cfg_valid <= 1'b0;
        case (idx)
            CFG_LEAD_SEP:  rg_lead_sep  = val[15:0];
            CFG_SURROUND:  rg_surround  = val[15:0];
            CFG_ENV:       rg_env       = val[23:0];
            CFG_MAP_FROM:  rg_map_from  = val;
            CFG_MAP_TO:    rg_map_to    = val;
            CFG_MAP_COUNT: rg_map_count = val[3:0];
            CFG_GB_MODE:   rg_gb        = val[0];
            CFG_OUT_LIMIT: rg_out_limit = val[15:0];
            default: ;
        endcase
        reg_writes++;
    endtask

    // nothing queued, nothing in flight, then a short settle
    task automatic wait_idle();
        @(posedge clk);
        while ((tx_q.size() != 0) || s_axis_tvalid || (exp_q.size() != 0))
            @(posedge clk);
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    task automatic add(input logic [7:0] b);
        tx_q.push_back(b);
        stim_items++;
    endtask

    function automatic logic [7:0] rand_char(input int zero_pct);
        int r;
        r = $urandom_range(0, 99);
        if (r < zero_pct)
            return 8'h00;
        if (r < 85)
            return 8'($urandom_range(33, 126));
        return 8'($urandom_range(1, 255));
    endfunction

    // a character from the current settings, or a random one where that setting is zero
    function automatic logic [7:0] config_char();
        logic [7:0] c;
        int         entry;
        entry = $urandom_range(0, 7);
        case ($urandom_range(0, 7))
            0:       c = rg_lead_sep[7:0];
            1:       c = rg_lead_sep[15:8];
            2:       c = rg_surround[7:0];
            3:       c = rg_surround[15:8];
            4:       c = rg_env[7:0];
            5:       c = rg_env[15:8];
            6:       c = rg_env[23:16];
            default: c = rg_map_from[8*entry +: 8];
        endcase
        if (c == 8'h00)
            c = 8'($urandom_range(1, 255));
        return c;
    endfunction

    function automatic logic [7:0] pick_byte();
        int r;
        r = $urandom_range(0, 99);
        if (r < 30)
            return config_char();
        if (r < 55)
            return 8'($urandom_range(32, 126));
        if (r < 75)
            return 8'($urandom_range(1, 255));
        return 8'($urandom_range(128, 255));
    endfunction

    task automatic push_gb_seq();
        logic [7:0] trail;
        case ($urandom_range(0, 5))
            0, 1:
            begin
                trail = 8'($urandom_range(8'h40, 8'hFE));
                if (trail == GB_TRAIL_GAP)
                    trail = 8'h80;
                add(8'($urandom_range(8'h81, 8'hFE)));
                add(trail);
            end
            2:
            begin
                add(8'($urandom_range(8'h81, 8'hFE)));
                add(8'($urandom_range(8'h30, 8'h39)));
                add(8'($urandom_range(8'h81, 8'hFE)));
                add(8'($urandom_range(8'h30, 8'h39)));
            end
            3:
            begin
                add(8'($urandom_range(8'h81, 8'hFE)));
                case ($urandom_range(0, 2))
                    0:       add(8'h7F);
                    1:       add(8'hFF);
                    default: add(8'($urandom_range(1, 8'h2F)));
                endcase
            end
            4:
            begin
                add(8'($urandom_range(8'h81, 8'hFE)));
                add(8'($urandom_range(8'h30, 8'h39)));
                add(8'($urandom_range(1, 8'h80)));
            end
            default:
            begin
                add(8'($urandom_range(8'h81, 8'hFE)));
                add(8'($urandom_range(8'h30, 8'h39)));
                add(8'($urandom_range(8'h81, 8'hFE)));
                add(8'($urandom_range(8'h3A, 8'hFF)));
            end
        endcase
    endtask

    task automatic push_string(input int len, input bit term);
        int i;
        for (i = 0; i < len; i++)
        begin
            if (rg_gb && ($urandom_range(0, 99) < 30))
                push_gb_seq();
            else
                add(pick_byte());
        end
        if (term)
            add(8'h00);
    endtask

    task automatic set_regs(input int phase);
        logic [63:0] mf;
        logic [63:0] mt;
        logic [15:0] lim;
        int          i;
        int          r;
        if (phase == 0)
        begin
            write_reg(CFG_LEAD_SEP, 64'hFFFF);
            write_reg(CFG_SURROUND, 64'hFFFF);
            write_reg(CFG_ENV, 64'hFF_FFFF);
            write_reg(CFG_MAP_FROM, '1);
            write_reg(CFG_MAP_TO, '1);
            write_reg(CFG_MAP_COUNT, 64'hF);
            write_reg(CFG_GB_MODE, 64'h1);
            write_reg(CFG_OUT_LIMIT, 64'hFFFF);
            return;
        end
        if (phase == 1)
        begin
            write_reg(CFG_LEAD_SEP, '0);
            write_reg(CFG_SURROUND, '0);
            write_reg(CFG_ENV, '0);
            write_reg(CFG_MAP_FROM, '0);
            write_reg(CFG_MAP_TO, '0);
            write_reg(CFG_MAP_COUNT, '0);
            write_reg(CFG_GB_MODE, '0);
            write_reg(CFG_OUT_LIMIT, '0);
            return;
        end
        for (i = 0; i < 8; i++)
        begin
            mf[8*i +: 8] = ($urandom_range(0, 99) < 15) ? 8'($urandom_range(128, 255))
                                                         : 8'($urandom_range(1, 127));
            mt[8*i +: 8] = ($urandom_range(0, 99) < 15) ? 8'h00 : 8'($urandom_range(1, 255));
        end
        r = $urandom_range(0, 99);
        if (r < 15)
            lim = 16'($urandom_range(0, 12));
        else if (r < 35)
            lim = 16'($urandom_range(13, 48));
        else if (r < 45)
            lim = 16'hFFFF;
        else
            lim = 16'($urandom_range(49, 4000));
        write_reg(CFG_LEAD_SEP, {48'h0, rand_char(20), rand_char(10)});
        write_reg(CFG_SURROUND, ($urandom_range(0, 99) < 30) ? 64'h0
                                : {48'h0, rand_char(0), rand_char(0)});
        write_reg(CFG_ENV, ($urandom_range(0, 99) < 30) ? 64'h0
                           : {40'h0, rand_char(0), rand_char(0), rand_char(0)});
        write_reg(CFG_MAP_FROM, mf);
        write_reg(CFG_MAP_TO, mt);
        write_reg(CFG_MAP_COUNT, 64'($urandom_range(0, 15)));
        write_reg(CFG_GB_MODE, 64'($urandom_range(0, 1)));
        write_reg(CFG_OUT_LIMIT, {48'h0, lim});
    endtask

    initial
    begin
        int phase;
        int phase_end;
        repeat (12) @(posedge clk);
        rst_n <= 1'b1;

        // default settings: lead escapes itself, extremes pass through
        add(8'h5C);
        add(8'hFF);
        add(8'h01);
        add(8'h00);
        wait_idle();

        // gb pairs and four-byte sequences, separator, surround, env and map escapes, map count clamped to 8
        write_reg(CFG_LEAD_SEP, 64'h3B5C);
        write_reg(CFG_SURROUND, 64'h2722);
        write_reg(CFG_ENV, 64'h7B7D24);
        write_reg(CFG_MAP_FROM, 64'h2600_0000_410D_090A);
        write_reg(CFG_MAP_TO, 64'h6100_0000_0072_746E);
        write_reg(CFG_MAP_COUNT, 64'hF);
        write_reg(CFG_GB_MODE, 64'h1);
        src_idle_on  = 1'b1;
        sink_idle_on = 1'b1;
        add(8'h81);
        add(8'h40);
        add(8'h81);
        add(8'h30);
        add(8'h81);
        add(8'h30);
        add(8'h0A);
        add(8'h41);
        add(8'h26);
        add(8'h22);
        add(8'h24);
        add(8'h3B);
        add(8'h81);
        add(8'h30);
        add(8'h00);
        add(8'h81);
        wait_idle();

        // held lead byte judged under new settings; zero limit, then zero lead near the limit
        write_reg(CFG_LEAD_SEP, 64'h3B00);
        write_reg(CFG_GB_MODE, 64'h0);
        write_reg(CFG_OUT_LIMIT, 64'h0);
        add(8'h22);
        add(8'h00);
        wait_idle();
        write_reg(CFG_OUT_LIMIT, 64'h5);
        add(8'h41);
        add(8'h22);
        add(8'h41);
        add(8'h3B);
        add(8'h41);
        add(8'h00);
        wait_idle();

        stim_items = 0;
        phase = 0;
        while (stim_items < RANDOM_ITEMS)
        begin
            set_regs(phase);
            src_idle_on  = (phase == 2) ? 1'b0 : bit'($urandom_range(0, 1));
            sink_idle_on = (phase == 2) ? 1'b0 : bit'($urandom_range(0, 1));
            phase_end = stim_items + $urandom_range(35, 65);
            while (stim_items < phase_end)
            begin
                if ($urandom_range(0, 9) == 0)
                    push_string($urandom_range(30, 60), 1'b1);
                else
                    push_string($urandom_range(0, 20), 1'b1);
            end
            // leave a partial string held across the next register writes
            if ($urandom_range(0, 1) == 1)
                push_string($urandom_range(1, 3), 1'b0);
            if ((phase == 3) || (phase == 7))
            begin
                src_idle_on = 1'b0;
                hold_req++;
            end
            wait_idle();
            phase++;
        end

        if (exp_q.size() != 0)
        begin
            err_count++;
            $display("%0d expected beats never arrived", exp_q.size());
        end
        $display("run covered %0d input bytes and %0d output beats over %0d strings",
                 bytes_in, beats_seen, strings_done);
        $display("%0d strings hit the output limit, %0d register writes, %0d errors",
                 ovf_strings, reg_writes, err_count);
        if (err_count == 0)
            $display("status: pass");
        else
            $display("status: fail");
        $finish;
    end

endmodule

// ===== filelist.f =====
+incdir+sv
sv/cbe_pkg.sv
sv/cbe_front.sv
sv/cbe_queue.sv
sv/cbe_back.sv
sv/configurable_byte_escaper_core.sv
verif/tb_top.sv
